// ===== rtl/ihf_pkg.sv =====
// Shared types and constants for the IPv4 header filter.
// No dependencies; used by every module under rtl/.
package ihf_pkg;

   // Header layout, as byte positions within a frame
   localparam int unsigned POS_W = 5;
   localparam logic [POS_W-1:0] POS_TOTAL_LEN_HI = 5'd2;
   localparam logic [POS_W-1:0] POS_TOTAL_LEN_LO = 5'd3;
   localparam logic [POS_W-1:0] POS_PROTOCOL     = 5'd9;
   localparam logic [POS_W-1:0] POS_CHECKSUM_HI  = 5'd10;
   localparam logic [POS_W-1:0] POS_CHECKSUM_LO  = 5'd11;
   localparam logic [POS_W-1:0] POS_SOURCE_FIRST = 5'd12;
   localparam logic [POS_W-1:0] POS_SOURCE_LAST  = 5'd15;
   localparam logic [POS_W-1:0] POS_DEST_FIRST   = 5'd16;
   localparam logic [POS_W-1:0] POS_DEST_LAST    = 5'd19;
   localparam logic [POS_W-1:0] POS_HEADER_END   = 5'd20;

   localparam int unsigned SUM_W = 20;
   localparam logic [15:0] HEADER_LEN = 16'd20;

   // Result beat layout
   localparam int unsigned RSP_TDATA_W = 56;
   localparam int unsigned RSP_PAD_W   = RSP_TDATA_W - 3 - 32 - 16;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_MY_ADDRESS      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WANTED_PROTOCOL = 8'd1;

   typedef enum logic [2:0] {
      VERDICT_ACCEPTED       = 3'd0,
      VERDICT_TOO_SHORT      = 3'd1,
      VERDICT_BAD_CHECKSUM   = 3'd2,
      VERDICT_NOT_MINE       = 3'd3,
      VERDICT_WRONG_PROTOCOL = 3'd4
   } verdict_type;

   typedef struct packed {
      logic [31:0] my_address;
      logic [7:0]  wanted_protocol;
   } ihf_cfg_type;

   // Header fields of one finished frame
   typedef struct packed {
      logic             too_short;
      logic [SUM_W-1:0] word_sum;
      logic [15:0]      received_checksum;
      logic [15:0]      total_length;
      logic [7:0]       protocol;
      logic [31:0]      source;
      logic [31:0]      destination;
   } ihf_snap_type;

endpackage

// ===== rtl/ihf_hdr_capture.sv =====
// Input register and per-frame header capture for the IPv4 header filter.
// Depends on ihf_pkg; hands one header snapshot per frame to ihf_verdict.
module ihf_hdr_capture (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] frame_byte
   input  logic                 req_tlast,   // last_byte
   output logic                 snap_valid,
   input  logic                 snap_ready,
   output ihf_pkg::ihf_snap_type snap
);
   import ihf_pkg::*;

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;

   logic [POS_W-1:0] pos_ff, pos_in, pos_upd;
   logic [SUM_W-1:0] sum_ff, sum_in, sum_upd;
   logic [7:0]       hold_ff, hold_in, hold_upd;
   logic [15:0]      chk_ff, chk_in, chk_upd;
   logic [15:0]      len_ff, len_in, len_upd;
   logic [7:0]       proto_ff, proto_in, proto_upd;
   logic [31:0]      src_ff, src_in, src_upd;
   logic [31:0]      dst_ff, dst_in, dst_upd;

   logic             snap_valid_ff, snap_valid_in;
   ihf_snap_type     snap_ff;

   logic             step_ready;
   logic             step_fire;
   logic             frame_done;

   // A final byte needs a free snapshot slot; other bytes always go through
   assign step_ready = !in_last_ff || !snap_valid_ff || snap_ready;
   assign step_fire  = in_valid_ff && step_ready;
   assign frame_done = step_fire && in_last_ff;
   assign req_tready = !in_valid_ff || step_ready;

   assign in_valid_in   = req_tready ? req_tvalid : in_valid_ff;
   assign snap_valid_in = frame_done ? 1'b1 : (snap_ready ? 1'b0 : snap_valid_ff);

   // Apply one byte to the header fields
   always_comb begin
      pos_upd   = pos_ff;
      sum_upd   = sum_ff;
      hold_upd  = hold_ff;
      chk_upd   = chk_ff;
      len_upd   = len_ff;
      proto_upd = proto_ff;
      src_upd   = src_ff;
      dst_upd   = dst_ff;
      if (pos_ff < POS_HEADER_END) begin
         pos_upd = pos_ff + 5'd1;
         // even byte opens a word, odd byte closes it; checksum word stays out
         if (!pos_ff[0]) begin
            hold_upd = in_byte_ff;
         end else if (pos_ff != POS_CHECKSUM_LO) begin
            sum_upd = sum_ff + {4'b0, hold_ff, in_byte_ff};
         end
         if (pos_ff inside {POS_TOTAL_LEN_HI, POS_TOTAL_LEN_LO}) begin
            len_upd = {len_ff[7:0], in_byte_ff};
         end else if (pos_ff == POS_PROTOCOL) begin
            proto_upd = in_byte_ff;
         end else if (pos_ff inside {POS_CHECKSUM_HI, POS_CHECKSUM_LO}) begin
            chk_upd = {chk_ff[7:0], in_byte_ff};
         end else if (pos_ff inside {[POS_SOURCE_FIRST:POS_SOURCE_LAST]}) begin
            src_upd = {src_ff[23:0], in_byte_ff};
         end else if (pos_ff inside {[POS_DEST_FIRST:POS_DEST_LAST]}) begin
            dst_upd = {dst_ff[23:0], in_byte_ff};
         end
      end
   end

   // Advance on a plain byte, clear after a final byte, else hold
   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      hold_in  = hold_ff;
      chk_in   = chk_ff;
      len_in   = len_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      if (frame_done) begin
         pos_in   = '0;
         sum_in   = '0;
         hold_in  = '0;
         chk_in   = '0;
         len_in   = '0;
         proto_in = '0;
         src_in   = '0;
         dst_in   = '0;
      end else if (step_fire) begin
         pos_in   = pos_upd;
         sum_in   = sum_upd;
         hold_in  = hold_upd;
         chk_in   = chk_upd;
         len_in   = len_upd;
         proto_in = proto_upd;
         src_in   = src_upd;
         dst_in   = dst_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         pos_ff        <= '0;
         sum_ff        <= '0;
         hold_ff       <= '0;
         chk_ff        <= '0;
         len_ff        <= '0;
         proto_ff      <= '0;
         src_ff        <= '0;
         dst_ff        <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         snap_valid_ff <= snap_valid_in;
         pos_ff        <= pos_in;
         sum_ff        <= sum_in;
         hold_ff       <= hold_in;
         chk_ff        <= chk_in;
         len_ff        <= len_in;
         proto_ff      <= proto_in;
         src_ff        <= src_in;
         dst_ff        <= dst_in;
      end
   end

   // Capture the input beat and the finished header
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (frame_done) begin
         snap_ff.too_short         <= (pos_upd < POS_HEADER_END);
         snap_ff.word_sum          <= sum_upd;
         snap_ff.received_checksum <= chk_upd;
         snap_ff.total_length      <= len_upd;
         snap_ff.protocol          <= proto_upd;
         snap_ff.source            <= src_upd;
         snap_ff.destination       <= dst_upd;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

// ===== rtl/ihf_verdict.sv =====
// Checksum fold, frame verdict and result register for the IPv4 header filter.
// Depends on ihf_pkg; fed by ihf_hdr_capture.
module ihf_verdict (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              snap_valid,
   output logic                              snap_ready,
   input  ihf_pkg::ihf_snap_type              snap,
   input  ihf_pkg::ihf_cfg_type               cfg,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] verdict, [34:3] source_address, [50:35] payload_length, rest zero
   output logic [ihf_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import ihf_pkg::*;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic [16:0] fold_one;
   logic [15:0] fold_two;
   logic [15:0] computed;
   verdict_type verdict;
   logic [31:0] source_out;
   logic [15:0] length_out;
   logic        load;

   assign snap_ready   = !rsp_valid_ff || rsp_tready;
   assign load         = snap_valid && snap_ready;
   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Fold carries twice, then complement
   assign fold_one = {1'b0, snap.word_sum[15:0]} + {13'b0, snap.word_sum[SUM_W-1:16]};
   assign fold_two = fold_one[15:0] + {15'b0, fold_one[16]};
   assign computed = ~fold_two;

   // Pick the verdict in priority order
   always_comb begin
      source_out = snap.source;
      length_out = (snap.total_length > HEADER_LEN) ? (snap.total_length - HEADER_LEN)
                                                    : 16'd0;
      if (snap.too_short) begin
         verdict    = VERDICT_TOO_SHORT;
         source_out = '0;
         length_out = '0;
      end else if (computed != snap.received_checksum) begin
         verdict = VERDICT_BAD_CHECKSUM;
      end else if (snap.destination != cfg.my_address) begin
         verdict = VERDICT_NOT_MINE;
      end else if (snap.protocol != cfg.wanted_protocol) begin
         verdict = VERDICT_WRONG_PROTOCOL;
      end else begin
         verdict = VERDICT_ACCEPTED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result beat until taken
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, length_out, source_out, verdict};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/ipv4_header_filter_top.sv =====
// IPv4 header filter: takes one frame byte per cycle and gives one result beat per frame.
// Takes a new byte in every cycle unless stalled; a result beat passes the input register,
// header capture and result register after its frame's final byte is accepted. The byte
// stream stalls only when a final byte meets a full snapshot stage and a result beat
// still waiting downstream. Bytes past the first 20 are counted out and ignored. The
// configuration port is always ready; write it only while no frame is in flight.
// Depends on ihf_pkg, ihf_hdr_capture and ihf_verdict.
module ipv4_header_filter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] frame_byte
   input  logic                                req_tlast,   // last_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] verdict, [34:3] source_address, [50:35] payload_length, rest zero
   output logic [ihf_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ihf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_data
);
   import ihf_pkg::*;

   ihf_cfg_type  cfg_ff, cfg_in;
   logic         snap_valid;
   logic         snap_ready;
   ihf_snap_type snap;

   assign csr_ready = 1'b1;

   // Decode configuration writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MY_ADDRESS:      cfg_in.my_address      = csr_data;
            CSR_WANTED_PROTOCOL: cfg_in.wanted_protocol = csr_data[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ihf_hdr_capture u_capture (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   ihf_verdict u_verdict (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .cfg        (cfg_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   // A new result beat always comes from a finished header snapshot
   a_rsp_from_snap: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(snap_valid))
      else $error("result beat without a header snapshot");

   // A short frame reports no address and no length
   a_short_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[2:0] == VERDICT_TOO_SHORT)) |-> (rsp_tdata[50:3] == '0))
      else $error("short frame carries header fields");

   // Payload length is saturated below the header size
   a_length_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[50:35] <= 16'd65515))
      else $error("payload length out of range");
`endif

endmodule
